FILE: sv/assert_macros.svh
// Concurrent assertion helpers for the region histogram block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RHMM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RHMM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHMM_ASSERT(lbl, clk, rstn, prop, msg)
`define RHMM_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: sv/rhmm_pkg.sv
`default_nettype none

package rhmm_pkg;

  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned NUM_BINS   = 256;
  localparam int unsigned BIN_W      = 8;
  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned CH_W       = 2;
  localparam int unsigned CNT_W      = 25;
  localparam int unsigned AREA_W     = 25;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned RAM_DEPTH  = NUM_CH * NUM_BINS;
  localparam int unsigned RAM_AW     = CH_W + BIN_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_REGION_LEFT   = 3'd2,
    CFG_REGION_TOP    = 3'd3,
    CFG_REGION_WIDTH  = 3'd4,
    CFG_REGION_HEIGHT = 3'd5
  } cfg_idx_e;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/rhmm_if.sv
`default_nettype none

interface rhmm_pix_if;
  logic                       valid;
  logic                       ready;
  logic [rhmm_pkg::BIN_W-1:0] red;
  logic [rhmm_pkg::BIN_W-1:0] green;
  logic [rhmm_pkg::BIN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rhmm_res_if;
  logic                       valid;
  logic                       ready;
  logic [rhmm_pkg::BIN_W-1:0] median_gray;
  logic [rhmm_pkg::BIN_W-1:0] median_red;
  logic [rhmm_pkg::BIN_W-1:0] median_green;
  logic [rhmm_pkg::BIN_W-1:0] median_blue;
  logic [rhmm_pkg::BIN_W-1:0] mean_gray;
  logic [rhmm_pkg::BIN_W-1:0] mean_red;
  logic [rhmm_pkg::BIN_W-1:0] mean_green;
  logic [rhmm_pkg::BIN_W-1:0] mean_blue;
  logic                       bad_region;

  modport source (output valid, median_gray, median_red, median_green, median_blue,
                  mean_gray, mean_red, mean_green, mean_blue, bad_region, input ready);
  modport sink (input valid, median_gray, median_red, median_green, median_blue,
                mean_gray, mean_red, mean_green, mean_blue, bad_region, output ready);
endinterface

`default_nettype wire

FILE: sv/rhmm_ram.sv
`default_nettype none

module rhmm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/region_histogram_median_mean.sv
// Channel  Dir  Handshake          Beat
// -------  ---  -----------------  -------------------------------------------------
// pix      in   valid/ready        red, green, blue (raster order)
// res      out  valid/ready        four medians, four means, bad_region (per frame)
// cfg      in   cfg_we_i only      cfg_idx_i selects register, cfg_data_i value
//
// A pixel outside the region leaves pix.ready high; one inside drops it in S_PIX for the
// read-modify-write of four bins through the single bin RAM port pair.
// The frame's last pixel starts, for each of the four channels, a scan of 256 bin reads,
// a drain and a divide, then the result register is loaded; pix.ready stays low until then.
// After reset the bin RAM is cleared, all 1024 entries, with pix.ready low.
// A pending result holds only the load of the next frame's result.
`default_nettype none
`include "assert_macros.svh"

module region_histogram_median_mean (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rhmm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [rhmm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  rhmm_pix_if.sink                                  pix,
  rhmm_res_if.source                                res
);

  localparam int unsigned DW  = rhmm_pkg::DIM_W;
  localparam int unsigned PW  = rhmm_pkg::POS_W;
  localparam int unsigned BW  = rhmm_pkg::BIN_W;
  localparam int unsigned CW  = rhmm_pkg::CNT_W;
  localparam int unsigned AW  = rhmm_pkg::AREA_W;
  localparam int unsigned SW  = rhmm_pkg::SUM_W;
  localparam int unsigned RAW = rhmm_pkg::RAM_AW;
  localparam int unsigned NCH = rhmm_pkg::NUM_CH;
  localparam int unsigned HW  = rhmm_pkg::CH_W;

  localparam logic [2:0]     PIX_STEPS = 3'(NCH);
  localparam logic [3:0]     DIV_TOP   = 4'(BW);
  localparam logic [HW-1:0]  LAST_CH   = HW'(NCH - 1);
  localparam logic [BW-1:0]  LAST_BIN  = BW'(rhmm_pkg::NUM_BINS - 1);
  localparam logic [RAW-1:0] LAST_ADDR = RAW'(rhmm_pkg::RAM_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PIX,
    S_SCAN,
    S_DRAIN,
    S_DIV,
    S_OUT
  } state_e;

  // configuration
  logic [DW-1:0] img_w_q, img_h_q, reg_w_q, reg_h_q;
  logic [PW-1:0] reg_l_q, reg_t_q;
  logic [DW-1:0] iw_c, ih_c, rw_c, rh_c;

  // control
  state_e         state_q;
  logic [PW-1:0]  col_q, row_q;
  logic           last_q;
  logic [2:0]     step_q;
  logic [HW-1:0]  chan_q;
  logic [BW-1:0]  bin_q;
  logic [3:0]     div_cnt_q;
  logic [RAW-1:0] clr_q;
  logic           rd_vld_q, prod_vld_q, res_vld_q;

  // datapath
  logic [BW-1:0]  pbin_q [NCH];
  logic [BW-1:0]  wbin_q, rd_bin_q, med_cur_q;
  logic [AW-1:0]  area_q;
  logic [CW-1:0]  cum_q;
  logic           found_q;
  logic [SW-1:0]  prod_q, sum_q, rem_q;
  logic [SW:0]    dsr_q;
  logic [BW-2:0]  quo_q;
  logic           sat_q;
  logic [BW-1:0]  med_q [NCH];
  logic [BW-1:0]  mean_q [NCH];
  logic [BW-1:0]  res_med_q [NCH];
  logic [BW-1:0]  res_mean_q [NCH];
  logic           res_bad_q;

  // bin RAM
  logic           ram_we;
  logic [RAW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0]  ram_wdata, ram_rdata;

  logic                pix_acc, in_reg, col_end, row_end, last_pix;
  logic [DW+DW-1:0]    area_full;
  logic [12:0]         gray_sum;
  logic [DW:0]         reg_r, reg_b;
  logic [CW-1:0]       cum_d;
  logic [CW+BW-1:0]    prod_full;
  logic                ge, drain_done, div_done, out_free, scan_start, acc_clr, bad;
  logic [2:0]          step_m1;

  assign iw_c = rhmm_pkg::clamp_dim(img_w_q);
  assign ih_c = rhmm_pkg::clamp_dim(img_h_q);
  assign rw_c = rhmm_pkg::clamp_dim(reg_w_q);
  assign rh_c = rhmm_pkg::clamp_dim(reg_h_q);

  assign reg_r = {2'b00, reg_l_q} + {1'b0, rw_c};
  assign reg_b = {2'b00, reg_t_q} + {1'b0, rh_c};
  assign bad   = (reg_r > {1'b0, iw_c}) || (reg_b > {1'b0, ih_c});

  assign pix_acc  = pix.valid && pix.ready;
  assign in_reg   = (col_q >= reg_l_q) && ({2'b00, col_q} < reg_r) &&
                    (row_q >= reg_t_q) && ({2'b00, row_q} < reg_b);
  assign col_end  = ({1'b0, col_q} + DW'(1)) >= iw_c;
  assign row_end  = ({1'b0, row_q} + DW'(1)) >= ih_c;
  assign last_pix = col_end && row_end;

  assign gray_sum = 13'(pix.red) * 13'd11 + {1'b0, pix.green, 4'b0000} +
                    13'(pix.blue) * 13'd5;

  assign area_full = {{DW{1'b0}}, rw_c} * {{DW{1'b0}}, rh_c};
  assign cum_d     = cum_q + ram_rdata;
  assign prod_full = {{BW{1'b0}}, ram_rdata} * {{CW{1'b0}}, rd_bin_q};
  assign ge        = {1'b0, rem_q} >= dsr_q;

  assign drain_done = (state_q == S_DRAIN) && !rd_vld_q && !prod_vld_q;
  assign div_done   = (state_q == S_DIV) && (div_cnt_q == '0);
  assign out_free   = !res_vld_q || res.ready;
  assign scan_start = ((state_q == S_IDLE) && pix_acc && !in_reg && last_pix) ||
                      ((state_q == S_PIX) && (step_q == PIX_STEPS) && last_q);
  assign acc_clr    = scan_start || (div_done && (chan_q != LAST_CH));
  assign step_m1    = step_q - 3'd1;

  assign pix.ready = (state_q == S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    ram_raddr = {chan_q, bin_q};
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_PIX: begin
        ram_raddr = {step_q[HW-1:0], pbin_q[0]};
        ram_we    = (step_q != '0);
        ram_waddr = {step_m1[HW-1:0], wbin_q};
        ram_wdata = ram_rdata + CW'(1);
      end
      S_SCAN, S_DRAIN: begin
        ram_we    = rd_vld_q;
        ram_waddr = {chan_q, rd_bin_q};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  rhmm_ram #(
    .WIDTH (CW),
    .DEPTH (rhmm_pkg::RAM_DEPTH)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= DW'(rhmm_pkg::MAX_DIM);
      img_h_q <= DW'(rhmm_pkg::MAX_DIM);
      reg_l_q <= '0;
      reg_t_q <= '0;
      reg_w_q <= DW'(rhmm_pkg::MAX_DIM);
      reg_h_q <= DW'(rhmm_pkg::MAX_DIM);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rhmm_pkg::CFG_IMAGE_WIDTH:   img_w_q <= cfg_data_i;
        rhmm_pkg::CFG_IMAGE_HEIGHT:  img_h_q <= cfg_data_i;
        rhmm_pkg::CFG_REGION_LEFT:   reg_l_q <= cfg_data_i[PW-1:0];
        rhmm_pkg::CFG_REGION_TOP:    reg_t_q <= cfg_data_i[PW-1:0];
        rhmm_pkg::CFG_REGION_WIDTH:  reg_w_q <= cfg_data_i;
        rhmm_pkg::CFG_REGION_HEIGHT: reg_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      col_q      <= '0;
      row_q      <= '0;
      last_q     <= 1'b0;
      step_q     <= '0;
      chan_q     <= '0;
      bin_q      <= '0;
      div_cnt_q  <= '0;
      clr_q      <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      rd_vld_q   <= (state_q == S_SCAN);
      prod_vld_q <= rd_vld_q;
      if (res_vld_q && res.ready) begin
        res_vld_q <= 1'b0;
      end
      if (scan_start) begin
        chan_q <= '0;
        bin_q  <= '0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + RAW'(1);
          if (clr_q == LAST_ADDR) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pix_acc) begin
            last_q <= last_pix;
            col_q  <= col_end ? '0 : col_q + PW'(1);
            if (col_end) begin
              row_q <= row_end ? '0 : row_q + PW'(1);
            end
            if (in_reg) begin
              step_q  <= '0;
              state_q <= S_PIX;
            end else if (last_pix) begin
              state_q <= S_SCAN;
            end
          end
        end
        S_PIX: begin
          step_q <= step_q + 3'd1;
          if (step_q == PIX_STEPS) begin
            state_q <= last_q ? S_SCAN : S_IDLE;
          end
        end
        S_SCAN: begin
          bin_q <= bin_q + BW'(1);
          if (bin_q == LAST_BIN) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_done) begin
            div_cnt_q <= DIV_TOP;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q - 4'd1;
          if (div_done) begin
            if (chan_q == LAST_CH) begin
              state_q <= S_OUT;
            end else begin
              chan_q  <= chan_q + HW'(1);
              bin_q   <= '0;
              state_q <= S_SCAN;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            res_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    area_q <= area_full[AW-1:0];
    if (pix_acc) begin
      pbin_q[0] <= gray_sum[12:5];
      pbin_q[1] <= pix.red;
      pbin_q[2] <= pix.green;
      pbin_q[3] <= pix.blue;
    end
    if ((state_q == S_PIX) && (step_q != PIX_STEPS)) begin
      wbin_q <= pbin_q[0];
      for (int i = 0; i < NCH - 1; i++) begin
        pbin_q[i] <= pbin_q[i+1];
      end
    end
    if (acc_clr) begin
      cum_q     <= '0;
      sum_q     <= '0;
      found_q   <= 1'b0;
      med_cur_q <= '0;
    end
    if (state_q == S_SCAN) begin
      rd_bin_q <= bin_q;
    end
    if (rd_vld_q) begin
      cum_q  <= cum_d;
      prod_q <= prod_full[SW-1:0];
      if (!found_q && (cum_d >= {1'b0, area_q[AW-1:1]})) begin
        found_q   <= 1'b1;
        med_cur_q <= rd_bin_q;
      end
    end
    if (prod_vld_q) begin
      sum_q <= sum_q + prod_q;
    end
    if (drain_done) begin
      rem_q <= sum_q;
      dsr_q <= {area_q, {BW{1'b0}}};
      quo_q <= '0;
      sat_q <= 1'b0;
    end
    if (state_q == S_DIV) begin
      dsr_q <= dsr_q >> 1;
      if (ge) begin
        rem_q <= rem_q - dsr_q[SW-1:0];
      end
      if (div_cnt_q == DIV_TOP) begin
        sat_q <= ge;
      end else if (div_cnt_q != '0) begin
        quo_q <= {quo_q[BW-3:0], ge};
      end
      if (div_done) begin
        med_q[chan_q]  <= med_cur_q;
        mean_q[chan_q] <= sat_q ? {BW{1'b1}} : {quo_q, ge};
      end
    end
    if ((state_q == S_OUT) && out_free) begin
      res_bad_q <= bad;
      for (int i = 0; i < NCH; i++) begin
        res_med_q[i]  <= bad ? '0 : med_q[i];
        res_mean_q[i] <= bad ? '0 : mean_q[i];
      end
    end
  end

  assign res.valid        = res_vld_q;
  assign res.median_gray  = res_med_q[0];
  assign res.median_red   = res_med_q[1];
  assign res.median_green = res_med_q[2];
  assign res.median_blue  = res_med_q[3];
  assign res.mean_gray    = res_mean_q[0];
  assign res.mean_red     = res_mean_q[1];
  assign res.mean_green   = res_mean_q[2];
  assign res.mean_blue    = res_mean_q[3];
  assign res.bad_region   = res_bad_q;

  `RHMM_ASSERT(a_clear_writes_zero, clk_i, rst_ni, (state_q == S_CLEAR) |-> (ram_we && (ram_wdata == '0)), "clear pass must write zero")
  `RHMM_ASSERT(a_scan_write_lags_read, clk_i, rst_ni, ((state_q == S_SCAN) && rd_vld_q) |-> (ram_raddr == (ram_waddr + RAW'(1))), "scan write must trail read by one bin")
  `RHMM_ASSERT(a_pix_no_rw_collision, clk_i, rst_ni, ((state_q == S_PIX) && ram_we && (step_q != PIX_STEPS)) |-> (ram_raddr != ram_waddr), "bin update read and write collide")
  `RHMM_ASSERT(a_div_after_drain, clk_i, rst_ni, drain_done |=> ((state_q == S_DIV) && (div_cnt_q == DIV_TOP)), "divide must start after drain")

endmodule

`default_nettype wire
